// File: hdl/bba_pkg.sv
// Package for the bitmap block allocator: sizes, command and status codes,
// controller states and the scan result type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_BITS  = 64;
	localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW    = $clog2(NUM_WORDS);
	localparam int BIT_AW     = $clog2(WORD_BITS);
	localparam int IDX_W      = 12;
	localparam int CNT_W      = 13;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_TEST  = 2'd2
	} cmd_e;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RMW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              found;
		logic [BIT_AW-1:0] pos;
	} scan_t;

endpackage
`default_nettype wire

// File: hdl/bba_req_if.sv
// Request channel of the bitmap block allocator: valid/ready plus command fields.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if;
	logic                      valid;
	logic                      ready;
	logic [bba_pkg::CMD_W-1:0] command;
	logic [bba_pkg::IDX_W-1:0] block_index;

	modport source (output valid, output command, output block_index, input ready);
	modport sink (input valid, input command, input block_index, output ready);
endinterface
`default_nettype wire

// File: hdl/bba_rsp_if.sv
// Response channel of the bitmap block allocator: valid/ready plus result fields.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bba_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [bba_pkg::IDX_W-1:0]  block_number;
	logic [bba_pkg::STAT_W-1:0] status;
	logic                       bit_value;
	logic [bba_pkg::CNT_W-1:0]  free_count;

	modport source (output valid, output block_number, output status,
		output bit_value, output free_count, input ready);
	modport sink (input valid, input block_number, input status,
		input bit_value, input free_count, output ready);
endinterface
`default_nettype wire

// File: hdl/bitmap_block_allocator_core.sv
// Top level of the bitmap block allocator: controller, bitmap RAM and word scan.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ram and bba_scan.
//
// Usage:
//   A request on req carries a command (allocate, free, test) and a block index.
//   Exactly one response follows on rsp for every request, in request order.
//   The used/free bitmap sits in a 64 x 64-bit RAM; each word has a valid flop
//   so that an unwritten word reads as all free.
//   Free and test take one RAM read and an optional write back; an out-of-range
//   index skips the RAM and goes straight to the response.
//   Allocate reads one bitmap word per cycle from word 0 upward until a clear
//   bit below the limit is found, or answers full once the last word that can
//   hold such a bit has been read.
//   One request is handled at a time; req.ready is high only while idle, and the
//   controller is idle again once the response is loaded.
//   The response sits in an output register; while the receiver stalls a
//   finished response waits in the controller and the next request is held off.
//   Reset clears the bitmap (by clearing the word valid flags), sets the limit
//   and the free count to 4096. Writing cfg_wdata with cfg_we, while idle,
//   sets a new limit and reformats the same way.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_block_allocator_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [bba_pkg::CNT_W-1:0] cfg_wdata,
	bba_req_if.sink                        req,
	bba_rsp_if.source                      rsp
);
	import bba_pkg::*;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     free_cnt_q;
	logic [NUM_WORDS-1:0] word_valid_q;
	logic [WORD_AW-1:0]   word_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     res_num_q;
	logic [STAT_W-1:0]    res_status_q;
	logic                 res_bit_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_num_q;
	logic [STAT_W-1:0]    out_status_q;
	logic                 out_bit_q;
	logic [CNT_W-1:0]     out_cnt_q;

	logic [CNT_W-1:0]     limit;
	logic [CNT_W-1:0]     cfg_limit;
	logic                 accept;
	logic                 req_out_of_range;
	logic [WORD_AW-1:0]   cur_word;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] word_eff;
	logic [WORD_BITS-1:0] bit_sel;
	logic                 cur_bit;
	logic                 last_word;
	logic                 rsp_load;
	scan_t                scan;

	logic                 ram_we;
	logic [WORD_AW-1:0]   ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WORD_AW-1:0]   ram_raddr;

	localparam int HI_W = CNT_W - BIT_AW;

	assign limit     = (total_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_q;
	assign cfg_limit = (cfg_wdata > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_wdata;

	assign req.ready        = (state_q == ST_IDLE);
	assign accept           = req.valid && req.ready;
	assign req_out_of_range = (CNT_W'(req.block_index) >= limit);

	// Word whose read data is arriving this cycle; an unwritten word is all free.
	assign cur_word = (state_q == ST_SCAN) ? word_q : idx_q[IDX_W-1:BIT_AW];
	assign word_eff = word_valid_q[cur_word] ? ram_rdata : '0;
	assign bit_sel  = WORD_BITS'(1) << idx_q[BIT_AW-1:0];
	assign cur_bit  = |(word_eff & bit_sel);

	// No bit of any later word can lie below the limit.
	assign last_word = (word_q == WORD_AW'(NUM_WORDS - 1)) ||
		(HI_W'(word_q) >= limit[CNT_W-1:BIT_AW]);

	assign rsp_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	bba_scan u_scan (
		.word_data (word_eff),
		.word_idx  (word_q),
		.limit     (limit),
		.result    (scan)
	);

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cur_word;
		ram_wdata = word_eff;
		ram_re    = 1'b0;
		ram_raddr = word_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.command == CMD_ALLOC) begin
						ram_re    = 1'b1;
						ram_raddr = '0;
						state_d   = ST_SCAN;
					end else if (req_out_of_range) begin
						state_d = ST_DONE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = req.block_index[IDX_W-1:BIT_AW];
						state_d   = ST_RMW;
					end
				end
			end
			ST_SCAN: begin
				if (scan.found) begin
					ram_we    = 1'b1;
					ram_wdata = word_eff | (WORD_BITS'(1) << scan.pos);
					state_d   = ST_DONE;
				end else if (last_word) begin
					state_d = ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = word_q + WORD_AW'(1);
				end
			end
			ST_RMW: begin
				if ((cmd_q == CMD_FREE) && cur_bit) begin
					ram_we    = 1'b1;
					ram_wdata = word_eff & ~bit_sel;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			total_q      <= CNT_W'(MAX_BLOCKS);
			free_cnt_q   <= CNT_W'(MAX_BLOCKS);
			word_valid_q <= '0;
			word_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					word_q <= '0;
				end
				ST_SCAN: begin
					if (scan.found) begin
						word_valid_q[word_q] <= 1'b1;
						if (free_cnt_q != '0) begin
							free_cnt_q <= free_cnt_q - CNT_W'(1);
						end
					end else if (!last_word) begin
						word_q <= word_q + WORD_AW'(1);
					end
				end
				ST_RMW: begin
					if ((cmd_q == CMD_FREE) && cur_bit) begin
						word_valid_q[cur_word] <= 1'b1;
						if (free_cnt_q < limit) begin
							free_cnt_q <= free_cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
			// Reformat: every word reads as free and the count follows the new limit.
			if (cfg_we) begin
				total_q      <= cfg_wdata;
				free_cnt_q   <= cfg_limit;
				word_valid_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q     <= req.command;
					idx_q     <= req.block_index;
					res_num_q <= req.block_index;
					res_bit_q <= 1'b0;
					if ((req.command != CMD_ALLOC) && req_out_of_range) begin
						res_status_q <= STAT_RANGE;
					end else begin
						res_status_q <= STAT_OK;
					end
				end
			end
			ST_SCAN: begin
				if (scan.found) begin
					res_num_q <= {word_q, scan.pos};
				end else if (last_word) begin
					res_status_q <= STAT_FULL;
				end
			end
			ST_RMW: begin
				res_bit_q <= cur_bit;
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			out_num_q    <= res_num_q;
			out_status_q <= res_status_q;
			out_bit_q    <= res_bit_q;
			out_cnt_q    <= free_cnt_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.block_number = out_num_q;
	assign rsp.status       = out_status_q;
	assign rsp.bit_value    = out_bit_q;
	assign rsp.free_count   = out_cnt_q;
endmodule
`default_nettype wire

// File: hdl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/bba_scan.sv
// First-fit search over one bitmap word: masks bits at or above the block limit
// and finds the lowest clear bit. Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_scan (
	input  wire logic [bba_pkg::WORD_BITS-1:0] word_data,
	input  wire logic [bba_pkg::WORD_AW-1:0]   word_idx,
	input  wire logic [bba_pkg::CNT_W-1:0]     limit,
	output bba_pkg::scan_t                     result
);
	import bba_pkg::*;

	localparam int HI_W = CNT_W - BIT_AW;

	logic [WORD_BITS-1:0] eligible;
	logic [WORD_BITS-1:0] cand;
	logic [HI_W-1:0]      limit_word;

	assign limit_word = limit[CNT_W-1:BIT_AW];

	always_comb begin
		// Whole word below the limit, the partial word at the limit, or nothing.
		if (HI_W'(word_idx) < limit_word) begin
			eligible = '1;
		end else if (HI_W'(word_idx) == limit_word) begin
			eligible = (WORD_BITS'(1) << limit[BIT_AW-1:0]) - WORD_BITS'(1);
		end else begin
			eligible = '0;
		end
	end

	assign cand = ~word_data & eligible;

	always_comb begin
		result.found = |cand;
		result.pos   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				result.pos = BIT_AW'(i);
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/bitmap_block_allocator_core_tb.sv
// Self-checking testbench for bitmap_block_allocator_core: allocate, free and test
// requests are checked against a bitmap model kept in the bench, under several limits.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and the allocator RTL.
`timescale 1ns / 1ps
module bitmap_block_allocator_core_tb;
	import bba_pkg::*;

	// Command code 3 is not part of the enum; the block treats it as a test.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] block_index;
	} alloc_request_t;

	typedef struct packed {
		logic [IDX_W-1:0] block_number;
		status_e          status;
		logic             bit_value;
		logic [CNT_W-1:0] free_count;
	} alloc_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();

	bitmap_block_allocator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Bench copy of the allocator state.
	logic [MAX_BLOCKS-1:0] used_map;
	logic [CNT_W-1:0]      free_blocks;
	int unsigned           blocks_limit;

	alloc_request_t pending_requests[$];
	alloc_result_t  expected_results[$];
	alloc_request_t next_request;
	alloc_result_t  oldest_result;

	int unsigned requests_issued;
	int unsigned responses_seen;
	int unsigned error_count;
	int unsigned idle_cycles;
	int unsigned send_gap;
	int unsigned rx_stall;
	int unsigned long_hold_asks;
	int unsigned long_hold_taken;
	int unsigned limit_settings;
	int unsigned allocations_made;
	int unsigned full_replies;
	int unsigned range_replies;
	int unsigned blocks_released;
	bit          quiet_mode;

	always #10 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void reformat(int unsigned value);
		blocks_limit = (value > MAX_BLOCKS) ? MAX_BLOCKS : value;
		used_map = '0;
		free_blocks = CNT_W'(blocks_limit);
	endfunction

	// Applies one request to the bench bitmap and returns the response it must produce.
	function automatic alloc_result_t compute_allocation(alloc_request_t r);
		alloc_result_t res;
		int unsigned b;
		bit found;
		res.block_number = r.block_index;
		res.status = STAT_OK;
		res.bit_value = 1'b0;
		found = 1'b0;
		b = 0;
		if (r.command == CMD_ALLOC) begin
			while (!found && b < blocks_limit) begin
				if (!used_map[b])
					found = 1'b1;
				else
					b++;
			end
			if (found) begin
				used_map[b] = 1'b1;
				if (free_blocks > 0)
					free_blocks--;
				res.block_number = IDX_W'(b);
				allocations_made++;
			end else begin
				res.status = STAT_FULL;
				full_replies++;
			end
		end else if (r.block_index >= blocks_limit) begin
			res.status = STAT_RANGE;
			range_replies++;
		end else begin
			res.bit_value = used_map[r.block_index];
			if (r.command == CMD_FREE && res.bit_value) begin
				used_map[r.block_index] = 1'b0;
				if (free_blocks < blocks_limit)
					free_blocks++;
				blocks_released++;
			end
		end
		res.free_count = free_blocks;
		return res;
	endfunction

	task automatic report_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Driver: offers queued requests, with random gaps between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				expected_results.push_back(compute_allocation({req_ch.command,
					req_ch.block_index}));
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					next_request = pending_requests.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.command <= next_request.command;
					req_ch.block_index <= next_request.block_index;
					send_gap = quiet_mode ? 0 : pick_gap();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every response and drives ready with random stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				responses_seen++;
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: response with nothing expected, block_number %0d status %0d",
						$time, rsp_ch.block_number, rsp_ch.status);
				end else begin
					oldest_result = expected_results.pop_front();
					report_field("block_number", oldest_result.block_number,
						rsp_ch.block_number);
					report_field("status", oldest_result.status, rsp_ch.status);
					report_field("bit_value", oldest_result.bit_value, rsp_ch.bit_value);
					report_field("free_count", oldest_result.free_count, rsp_ch.free_count);
				end
			end
			if (long_hold_asks != long_hold_taken) begin
				long_hold_taken = long_hold_asks;
				rx_stall = LONG_HOLD_CYCLES;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
				rx_stall = pick_gap();
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request or response moved for %0d cycles", $time, idle_cycles);
				$display("bitmap_block_allocator_core_tb failed");
				$finish;
			end
		end
	end

	task automatic queue_request(logic [CMD_W-1:0] command, logic [IDX_W-1:0] block_index);
		pending_requests.push_back({command, block_index});
		requests_issued++;
	endtask

	task automatic wait_drained();
		while (responses_seen != requests_issued)
			@(posedge clk);
	endtask

	// The block must be idle here, so everything issued is drained first.
	task automatic write_limit(logic [CNT_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		reformat(value);
		limit_settings++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(logic [CNT_W-1:0] limit_value, int unsigned count,
		int unsigned alloc_pct, bit quiet, bit long_hold);
		int unsigned allocs_made;
		int unsigned r;
		int unsigned top;
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] block_index;
		allocs_made = 0;
		write_limit(limit_value);
		quiet_mode = quiet;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct) begin
				command = CMD_ALLOC;
				allocs_made++;
			end else begin
				r = $urandom_range(0, 99);
				command = (r < 55) ? CMD_FREE : (r < 90) ? CMD_TEST : CMD_UNUSED;
			end
			// Mostly aim at blocks that are likely in use, sometimes anywhere.
			r = $urandom_range(0, 99);
			if (r < 50) begin
				top = allocs_made + 2;
				block_index = IDX_W'($urandom_range(0, (top > 4095) ? 4095 : top));
			end else if (r < 80) begin
				top = blocks_limit + 3;
				block_index = IDX_W'($urandom_range(0, (top > 4095) ? 4095 : top));
			end else begin
				block_index = IDX_W'($urandom());
			end
			queue_request(command, block_index);
			// Halfway through, the sender pauses until every response is back.
			if (n == count / 2) begin
				if (long_hold)
					long_hold_asks++;
				wait_drained();
			end
		end
		wait_drained();
		quiet_mode = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ALLOC;
		req_ch.block_index = '0;
		rsp_ch.ready = 1'b0;
		quiet_mode = 1'b0;
		reformat(MAX_BLOCKS);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset state: the full 4096-block limit.
		queue_request(CMD_ALLOC, 12'd0);
		queue_request(CMD_ALLOC, 12'hFFF);
		queue_request(CMD_TEST, 12'd0);
		queue_request(CMD_TEST, 12'd1);
		queue_request(CMD_TEST, 12'd2);
		queue_request(CMD_TEST, 12'hFFF);
		queue_request(CMD_FREE, 12'd0);
		queue_request(CMD_FREE, 12'd0);
		queue_request(CMD_ALLOC, 12'd5);
		queue_request(CMD_UNUSED, 12'd1);
		queue_request(CMD_FREE, 12'hFFF);

		// One block: fill it, then run into full and out-of-range indexes.
		write_limit(13'd1);
		queue_request(CMD_ALLOC, 12'd0);
		queue_request(CMD_ALLOC, 12'hABC);
		queue_request(CMD_FREE, 12'hFFF);
		queue_request(CMD_TEST, 12'd1);
		queue_request(CMD_FREE, 12'd0);
		queue_request(CMD_TEST, 12'd0);
		queue_request(CMD_UNUSED, 12'd0);

		// No blocks at all.
		write_limit(13'd0);
		queue_request(CMD_ALLOC, 12'h555);
		queue_request(CMD_FREE, 12'd0);
		queue_request(CMD_TEST, 12'd0);

		// A limit above the maximum is clamped.
		write_limit(13'h1FFF);
		queue_request(CMD_TEST, 12'hFFF);
		queue_request(CMD_ALLOC, 12'h0F0);

		random_phase(13'd4096, 60, 60, 1'b0, 1'b1);
		random_phase(CNT_W'($urandom_range(2, 40)), 60, 55, 1'b1, 1'b0);
		random_phase(13'h1FFF, 40, 50, 1'b0, 1'b0);
		random_phase(13'd1, 30, 40, 1'b0, 1'b0);
		random_phase(13'd64, 60, 75, 1'b0, 1'b0);
		random_phase(13'd100, 80, 85, 1'b0, 1'b0);
		random_phase(13'd0, 15, 30, 1'b1, 1'b0);
		random_phase(13'd4097, 60, 50, 1'b0, 1'b1);

		wait_drained();
		// Room for any stray response to show up before the verdict.
		repeat (100) @(posedge clk);
		if (expected_results.size() != 0) begin
			error_count++;
			$display("%0t: %0d responses never arrived", $time, expected_results.size());
		end
		$display("Ran %0d requests under %0d limit settings with %0d mismatches.",
			requests_issued, limit_settings, error_count);
		$display("Seen %0d allocations, %0d full, %0d out of range, %0d blocks released.",
			allocations_made, full_replies, range_replies, blocks_released);
		if (error_count == 0)
			$display("bitmap_block_allocator_core_tb passed");
		else
			$display("bitmap_block_allocator_core_tb failed");
		$finish;
	end
endmodule

// File: filelist.f
hdl/bba_pkg.sv
hdl/bba_req_if.sv
hdl/bba_rsp_if.sv
hdl/bba_ram.sv
hdl/bba_scan.sv
hdl/bitmap_block_allocator_core.sv
tb/bitmap_block_allocator_core_tb.sv
